### sv/plp_pkg.sv
// Package: shared types, constants and pattern ROM for the LED pattern player.
package plp_pkg;

    localparam int unsigned NumStatus = 9;
    localparam int unsigned SlotBits = 4;
    localparam int unsigned StatusBits = 4;
    localparam int unsigned PeriodBits = 16;
    localparam logic [PeriodBits-1:0] PeriodReset = 16'd50;
    localparam logic [PeriodBits-1:0] ElapsedMax = 16'hFFFF;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [StatusBits-1:0] status_index;
        logic                  flag_value;
    } t_item;

    typedef struct packed {
        logic                  red_on;
        logic                  green_on;
        logic [StatusBits-1:0] shown_status;
        logic                  slot_played;
    } t_result;

    localparam logic [15:0] RedRom [NumStatus] = '{
        16'hAAAA, 16'h0000, 16'h0000, 16'h0000, 16'h0101,
        16'hF000, 16'h0000, 16'hCCCC, 16'hFFFF
    };
    localparam logic [15:0] GreenRom [NumStatus] = '{
        16'h5555, 16'hFFFF, 16'hFF00, 16'hCCCC, 16'hFEFE,
        16'h0FFF, 16'h8080, 16'h0000, 16'h0000
    };

    function automatic logic [1:0] pattern_bits(input logic [StatusBits-1:0] status,
                                                input logic [SlotBits-1:0] slot);
        logic [15:0] red_w;
        logic [15:0] green_w;
        red_w   = 16'h0000;
        green_w = 16'h0000;
        for (int k = 0; k < NumStatus; k++) begin
            if (status == StatusBits'(k)) begin
                red_w   = RedRom[k];
                green_w = GreenRom[k];
            end
        end
        if (status >= StatusBits'(NumStatus)) begin
            red_w   = RedRom[0];
            green_w = GreenRom[0];
        end
        return {red_w[slot], green_w[slot]};
    endfunction

endpackage

### sv/plp_in_stage.sv
// Input register stage: holds one accepted transaction for the engine.
module plp_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  plp_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output plp_pkg::t_item o_item
);
    import plp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

### sv/plp_engine.sv
// Engine: status flags, priority select, slot timer and result register.
module plp_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [plp_pkg::PeriodBits-1:0]    i_cfg_period,
    input  logic                              i_valid,
    input  plp_pkg::t_item                    i_item,
    output logic                              o_take,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output plp_pkg::t_result                  o_result
);
    import plp_pkg::*;

    logic [NumStatus-1:0]  r_flags, n_flags;
    logic [StatusBits-1:0] r_sel, n_sel;
    logic [SlotBits-1:0]   r_slot, n_slot;
    logic [PeriodBits-1:0] r_elapsed, n_elapsed;
    logic                  r_red, n_red;
    logic                  r_green, n_green;
    logic [PeriodBits-1:0] r_period;
    logic                  r_out_valid;
    t_result               r_result, n_result;
    logic                  w_advance;
    logic                  w_fire;
    logic [PeriodBits-1:0] w_elapsed_inc;
    logic [StatusBits-1:0] w_top;
    logic [1:0]            w_bits;
    logic                  w_played;

    assign w_advance = !r_out_valid || i_out_ready;
    assign o_take    = w_advance;
    assign w_fire    = i_valid && w_advance;

    always_comb begin
        n_flags = r_flags;
        if (i_item.status_index < StatusBits'(NumStatus)) begin
            n_flags[i_item.status_index] = i_item.flag_value;
        end
        w_top = '0;
        for (int k = 0; k < NumStatus; k++) begin
            if (n_flags[k]) begin
                w_top = StatusBits'(k);
            end
        end
    end

    assign w_elapsed_inc = (r_elapsed == ElapsedMax) ? r_elapsed : r_elapsed + 1'b1;
    assign w_bits        = pattern_bits(r_sel, r_slot);

    always_comb begin
        n_sel     = r_sel;
        n_slot    = r_slot;
        n_elapsed = r_elapsed;
        n_red     = r_red;
        n_green   = r_green;
        w_played  = 1'b0;
        if (i_item.op == OP_SET) begin
            if (w_top != r_sel) begin
                n_sel  = w_top;
                n_slot = '0;
            end
        end else begin
            n_elapsed = w_elapsed_inc;
            if (w_elapsed_inc >= r_period) begin
                n_red     = w_bits[1];
                n_green   = w_bits[0];
                n_slot    = r_slot + 1'b1;
                n_elapsed = '0;
                w_played  = 1'b1;
            end
        end
        n_result.red_on       = n_red;
        n_result.green_on     = n_green;
        n_result.shown_status = n_sel;
        n_result.slot_played  = w_played;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= NumStatus'(1);
            r_sel       <= '0;
            r_slot      <= '0;
            r_elapsed   <= '0;
            r_red       <= 1'b0;
            r_green     <= 1'b0;
            r_period    <= PeriodReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_period;
            end
            if (w_fire) begin
                if (i_item.op == OP_SET) begin
                    r_flags <= n_flags;
                end
                r_sel     <= n_sel;
                r_slot    <= n_slot;
                r_elapsed <= n_elapsed;
                r_red     <= n_red;
                r_green   <= n_green;
            end
            if (w_advance) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
endmodule

### sv/priority_led_pattern_player_core.sv
// Top level: prioritized status LED pattern player.
// Path from input transaction to result: input register, then result register.
// Throughput: one transaction per cycle while i_out_ready does not stall the result register;
// the engine's state update loop (priority encoder, pattern ROM, slot timer) is combinational.
// Reset: synchronous active-low; flag 0 set, status 0, slot 0, LEDs off, period 50.
module priority_led_pattern_player_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_slot_period,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [3:0]  i_status_index,
    input  logic        i_flag_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_red_on,
    output logic        o_green_on,
    output logic [3:0]  o_shown_status,
    output logic        o_slot_played
);
    import plp_pkg::*;

    t_item   w_item_in;
    t_item   w_item;
    t_result w_result;
    logic    w_stage_valid;
    logic    w_take;

    assign o_cfg_ready = 1'b1;

    assign w_item_in.op           = t_op'(i_op);
    assign w_item_in.status_index = i_status_index;
    assign w_item_in.flag_value   = i_flag_value;

    plp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_item_in),
        .o_valid (w_stage_valid),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    plp_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_period (i_cfg_slot_period),
        .i_valid      (w_stage_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (w_result)
    );

    assign o_red_on       = w_result.red_on;
    assign o_green_on     = w_result.green_on;
    assign o_shown_status = w_result.shown_status;
    assign o_slot_played  = w_result.slot_played;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shown_status <= 4'd8))
        else $error("shown status out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && w_stage_valid) |-> !o_in_ready)
        else $error("input accepted while pipeline is full");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(w_result)))
        else $error("stalled result changed");

    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage_valid && (!o_out_valid || i_out_ready)) |=> o_out_valid)
        else $error("staged transaction did not reach result register");
endmodule

### tb/plp_checker.sv
// Checker: predicts LED pattern player results from accepted transactions and compares them.
module plp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_slot_period,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_op,
    input  logic [3:0]  i_status_index,
    input  logic        i_flag_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_red_on,
    input  logic        i_green_on,
    input  logic [3:0]  i_shown_status,
    input  logic        i_slot_played,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import plp_pkg::*;

    localparam int FlagCount = 9;

    localparam logic [15:0] RedPattern [FlagCount] = '{
        16'hAAAA, 16'h0000, 16'h0000, 16'h0000, 16'h0101,
        16'hF000, 16'h0000, 16'hCCCC, 16'hFFFF
    };
    localparam logic [15:0] GreenPattern [FlagCount] = '{
        16'h5555, 16'hFFFF, 16'hFF00, 16'hCCCC, 16'hFEFE,
        16'h0FFF, 16'h8080, 16'h0000, 16'h0000
    };

    logic [15:0]          period_ms;
    logic [FlagCount-1:0] active_flags;
    logic [3:0]           shown_status;
    logic [3:0]           slot;
    logic [15:0]          elapsed;
    logic                 red_level;
    logic                 green_level;
    t_result              led_results_q [$];
    int                   mismatches;

    initial begin
        o_pending  = 0;
        o_errors   = 0;
        mismatches = 0;
    end

    function automatic logic [3:0] top_flag(input logic [FlagCount-1:0] flags);
        logic [3:0] found;
        found = 4'd0;
        for (int k = 0; k < FlagCount; k++) begin
            if (flags[k]) begin
                found = 4'(k);
            end
        end
        return found;
    endfunction

    task automatic play_item(input t_op op, input logic [3:0] index, input logic value);
        t_result    res;
        logic [3:0] next_status;
        res.slot_played = 1'b0;
        if (op == OP_SET) begin
            if (index < 4'(FlagCount) && active_flags[index] != value) begin
                active_flags[index] = value;
                next_status = top_flag(active_flags);
                if (next_status != shown_status) begin
                    shown_status = next_status;
                    slot = 4'd0;
                end
            end
        end else begin
            if (elapsed != 16'hFFFF) begin
                elapsed = elapsed + 16'd1;
            end
            if (elapsed >= period_ms) begin
                red_level   = RedPattern[shown_status][slot];
                green_level = GreenPattern[shown_status][slot];
                slot        = slot + 4'd1;
                elapsed     = 16'd0;
                res.slot_played = 1'b1;
            end
        end
        res.red_on       = red_level;
        res.green_on     = green_level;
        res.shown_status = shown_status;
        led_results_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            period_ms    = 16'd50;
            active_flags = 9'b0_0000_0001;
            shown_status = 4'd0;
            slot         = 4'd0;
            elapsed      = 16'd0;
            red_level    = 1'b0;
            green_level  = 1'b0;
            led_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                period_ms = i_cfg_slot_period;
            end
            if (i_in_valid && i_in_ready) begin
                play_item(t_op'(i_op), i_status_index, i_flag_value);
            end
            if (i_out_valid && i_out_ready) begin
                if (led_results_q.size() == 0) begin
                    $display("%0t: unexpected result red=%0b green=%0b status=%0d played=%0b",
                             $time, i_red_on, i_green_on, i_shown_status, i_slot_played);
                    mismatches++;
                end else begin
                    want = led_results_q.pop_front();
                    if (i_red_on !== want.red_on) begin
                        $display("%0t: red_on expected %0b actual %0b",
                                 $time, want.red_on, i_red_on);
                        mismatches++;
                    end
                    if (i_green_on !== want.green_on) begin
                        $display("%0t: green_on expected %0b actual %0b",
                                 $time, want.green_on, i_green_on);
                        mismatches++;
                    end
                    if (i_shown_status !== want.shown_status) begin
                        $display("%0t: shown_status expected %0d actual %0d",
                                 $time, want.shown_status, i_shown_status);
                        mismatches++;
                    end
                    if (i_slot_played !== want.slot_played) begin
                        $display("%0t: slot_played expected %0b actual %0b",
                                 $time, want.slot_played, i_slot_played);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= led_results_q.size();
        o_errors  <= mismatches;
    end

endmodule

### tb/priority_led_pattern_player_core_tb.sv
// Testbench top: stimulus, receiver stalls and verdict for the LED pattern player core.
module priority_led_pattern_player_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plp_pkg::*;

    localparam int ClkPeriod  = 8;
    localparam int CycleLimit = 1500000;
    localparam int HoldCycles = 300;
    localparam int RxOpen     = 0;
    localparam int RxRandom   = 1;
    localparam int RxSparse   = 2;

    localparam logic [5:0] Directed [25] = '{
        {OP_SET,  4'd15, 1'b1}, {OP_SET,  4'd9,  1'b0}, {OP_SET,  4'd0,  1'b1},
        {OP_TICK, 4'd0,  1'b0}, {OP_TICK, 4'd15, 1'b1}, {OP_SET,  4'd8,  1'b1},
        {OP_TICK, 4'd0,  1'b0}, {OP_SET,  4'd8,  1'b1}, {OP_SET,  4'd3,  1'b1},
        {OP_SET,  4'd8,  1'b0}, {OP_TICK, 4'd0,  1'b0}, {OP_TICK, 4'd0,  1'b0},
        {OP_SET,  4'd0,  1'b0}, {OP_SET,  4'd3,  1'b0}, {OP_TICK, 4'd0,  1'b0},
        {OP_SET,  4'd5,  1'b1}, {OP_SET,  4'd6,  1'b1}, {OP_SET,  4'd7,  1'b1},
        {OP_SET,  4'd4,  1'b1}, {OP_SET,  4'd1,  1'b1}, {OP_SET,  4'd2,  1'b1},
        {OP_TICK, 4'd0,  1'b0}, {OP_SET,  4'd12, 1'b1}, {OP_SET,  4'd10, 1'b0},
        {OP_TICK, 4'd0,  1'b0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_slot_period = 16'd0;
    logic        in_valid = 1'b0;
    logic        op = 1'b0;
    logic [3:0]  status_index = 4'd0;
    logic        flag_value = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic        red_on;
    logic        green_on;
    logic [3:0]  shown_status;
    logic        slot_played;
    int          pending;
    int          errors;
    int          cycle_count = 0;
    int          hold_asked = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_mode = RxOpen;
    int          rx_left = 0;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    priority_led_pattern_player_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_slot_period (cfg_slot_period),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_op              (op),
        .i_status_index    (status_index),
        .i_flag_value      (flag_value),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_red_on          (red_on),
        .o_green_on        (green_on),
        .o_shown_status    (shown_status),
        .o_slot_played     (slot_played)
    );

    plp_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_slot_period (cfg_slot_period),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_op              (op),
        .i_status_index    (status_index),
        .i_flag_value      (flag_value),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_red_on          (red_on),
        .i_green_on        (green_on),
        .i_shown_status    (shown_status),
        .i_slot_played     (slot_played),
        .o_pending         (pending),
        .o_errors          (errors)
    );

    // receiver: own stall pattern, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_mode   <= RxOpen;
            rx_left   <= 0;
            hold_left <= 0;
        end else if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= HoldCycles;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(RxSparse, RxOpen);
                rx_left <= $urandom_range(200, 20);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RxOpen:   out_ready <= 1'b1;
                RxRandom: out_ready <= 1'($urandom_range(1));
                default:  out_ready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input t_op item_op, input logic [3:0] index, input logic value);
        in_valid     <= 1'b1;
        op           <= item_op;
        status_index <= index;
        flag_value   <= value;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_period(input logic [15:0] period);
        cfg_valid       <= 1'b1;
        cfg_slot_period <= period;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_items(input int count, input int tick_pct);
        int         burst_left;
        int         gap;
        logic [3:0] index;
        burst_left = $urandom_range(40, 1);
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(5, 0);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(40, 1);
            end
            burst_left--;
            if ($urandom_range(99) < tick_pct) begin
                send_item(OP_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
            end else begin
                index = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 9))
                                                 : 4'($urandom_range(8));
                send_item(OP_SET, index, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset period of 50: one slot plays
        run_items(60, 100);
        wait_drained();

        write_period(16'd1);
        for (int k = 0; k < 25; k++) begin
            send_item(t_op'(Directed[k][5]), Directed[k][4:1], Directed[k][0]);
        end
        run_items(100, 70);
        wait_drained();

        write_period(16'd0);
        run_items(100, 60);
        wait_drained();

        write_period(16'd3);
        hold_asked <= hold_asked + 1;
        run_items(150, 70);
        wait_drained();

        // long period: elapsed count builds up, then a short period plays at once
        write_period(16'hFFFF);
        run_items(40, 100);
        run_items(20, 50);
        wait_drained();

        write_period(16'($urandom_range(20, 2)));
        run_items(120, 70);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
